// File: hw/rtl/dual_stepper_route_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// dsrs assertion macros
// shared concurrent check wrappers, sampled on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef DUAL_STEPPER_ROUTE_SEQUENCER_CORE_MACROS_SVH
`define DUAL_STEPPER_ROUTE_SEQUENCER_CORE_MACROS_SVH

// condition holds at every sampled edge
`define DSRS_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("dsrs check failed");

// same-cycle implication
`define DSRS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsrs check failed");

// next-cycle implication
`define DSRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsrs check failed");

`endif

// File: hw/rtl/dsrs_pkg.sv
// ----------------------------------------------------------------------------
// dsrs_pkg
// types, route tables and step tables of the dual stepper route sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package dsrs_pkg;

  // route modes
  localparam logic [2:0] MODE_SINGLE = 3'd1;
  localparam logic [2:0] MODE_PAIR   = 3'd2;
  localparam logic [2:0] MODE_CROSS  = 3'd3;
  localparam logic [2:0] MODE_WAVE   = 3'd4;

  // sensor selectors
  localparam logic [2:0] SENS_NONE  = 3'd0;
  localparam logic [2:0] SENS_UNI_H = 3'd1;
  localparam logic [2:0] SENS_UNI_V = 3'd2;
  localparam logic [2:0] SENS_BI_V  = 3'd3;
  localparam logic [2:0] SENS_BI_H  = 3'd4;

  // step tables
  localparam logic [1:0] TAB_CW_FULL  = 2'd0;
  localparam logic [1:0] TAB_CCW_FULL = 2'd1;
  localparam logic [1:0] TAB_CW_WAVE  = 2'd2;
  localparam logic [1:0] TAB_CCW_WAVE = 2'd3;

  localparam logic [3:0] BI_CODE_RST = 4'b0100;

  // result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTRW  = $clog2(QDEPTH);
  localparam int unsigned QCNTW  = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    PH_POWER_HOME = 4'b0001,
    PH_MODE_HOME  = 4'b0010,
    PH_RUN        = 4'b0100,
    PH_HALT       = 4'b1000
  } phase_t;

  typedef struct packed {
    logic kind;
    logic uni_horizontal_sensor;
    logic uni_vertical_sensor;
    logic bi_vertical_sensor;
    logic bi_horizontal_sensor;
  } in_item_t;

  typedef struct packed {
    logic [7:0] drive_word;
    logic       error_flag;
    logic       homing;
    logic       last_of_run;
  } result_t;

  // results of one request, count 0 to 2
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } step_res_t;

  typedef struct packed {
    logic [2:0] usens;
    logic [1:0] utab;
    logic [2:0] bsens;
    logic [1:0] btab;
    logic       twice;
  } plan_t;

  typedef struct packed {
    logic [3:0] code;
    logic [1:0] phase;
    logic       half;
  } bi_st_t;

  localparam result_t ERR_RESULT = '{drive_word: 8'h00, error_flag: 1'b1,
                                     homing: 1'b0, last_of_run: 1'b1};

  function automatic plan_t make_plan(logic [2:0] us, logic [1:0] ut,
                                      logic [2:0] bs, logic [1:0] bt, logic tw);
    plan_t p;
    p.usens = us;
    p.utab  = ut;
    p.bsens = bs;
    p.btab  = bt;
    p.twice = tw;
    return p;
  endfunction

  // targets of the current segment
  function automatic plan_t plan_lookup(logic pwr_home, logic mode_home,
                                        logic [2:0] m, logic [1:0] seg);
    plan_t p;
    p = make_plan(SENS_NONE, TAB_CW_FULL, SENS_NONE, TAB_CW_FULL, 1'b0);
    if (pwr_home) begin
      p = make_plan(SENS_UNI_H, TAB_CCW_FULL, SENS_BI_H, TAB_CCW_FULL, 1'b0);
    end else if (mode_home) begin
      case (m)
        MODE_PAIR:  p = make_plan(SENS_UNI_H, TAB_CCW_FULL, SENS_BI_H, TAB_CCW_FULL, 1'b0);
        MODE_CROSS: p = make_plan(SENS_UNI_V, TAB_CCW_FULL, SENS_BI_H, TAB_CCW_FULL, 1'b0);
        MODE_WAVE:  p = make_plan(SENS_UNI_H, TAB_CW_WAVE, SENS_BI_H, TAB_CW_WAVE, 1'b0);
        default:    p = make_plan(SENS_NONE, TAB_CW_FULL, SENS_NONE, TAB_CW_FULL, 1'b0);
      endcase
    end else begin
      case (m)
        MODE_SINGLE: begin
          case (seg)
            2'd0:    p = make_plan(SENS_UNI_V, TAB_CCW_FULL, SENS_NONE, TAB_CW_FULL, 1'b0);
            2'd1:    p = make_plan(SENS_NONE, TAB_CW_FULL, SENS_BI_V, TAB_CW_FULL, 1'b0);
            2'd2:    p = make_plan(SENS_UNI_H, TAB_CW_FULL, SENS_NONE, TAB_CW_FULL, 1'b0);
            default: p = make_plan(SENS_NONE, TAB_CW_FULL, SENS_BI_H, TAB_CCW_FULL, 1'b0);
          endcase
        end
        MODE_PAIR: begin
          if (!seg[0]) p = make_plan(SENS_UNI_V, TAB_CCW_FULL, SENS_BI_V, TAB_CW_FULL, 1'b0);
          else         p = make_plan(SENS_UNI_H, TAB_CW_FULL, SENS_BI_H, TAB_CCW_FULL, 1'b0);
        end
        MODE_CROSS: begin
          if (!seg[0]) p = make_plan(SENS_UNI_H, TAB_CCW_FULL, SENS_BI_V, TAB_CCW_FULL, 1'b0);
          else         p = make_plan(SENS_UNI_V, TAB_CW_FULL, SENS_BI_H, TAB_CW_FULL, 1'b0);
        end
        MODE_WAVE: begin
          if (!seg[0]) p = make_plan(SENS_UNI_V, TAB_CCW_WAVE, SENS_BI_V, TAB_CW_WAVE, 1'b1);
          else         p = make_plan(SENS_UNI_H, TAB_CW_WAVE, SENS_BI_H, TAB_CCW_WAVE, 1'b1);
        end
        default: p = make_plan(SENS_NONE, TAB_CW_FULL, SENS_NONE, TAB_CW_FULL, 1'b0);
      endcase
    end
    return p;
  endfunction

  function automatic logic sens_pick(logic [2:0] sel, in_item_t it);
    logic s;
    case (sel)
      SENS_UNI_H: s = it.uni_horizontal_sensor;
      SENS_UNI_V: s = it.uni_vertical_sensor;
      SENS_BI_V:  s = it.bi_vertical_sensor;
      SENS_BI_H:  s = it.bi_horizontal_sensor;
      default:    s = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] uni_lookup(logic [1:0] tab, logic [1:0] ph);
    logic [3:0] c;
    case ({tab, ph})
      4'b00_00: c = 4'h3;
      4'b00_01: c = 4'h6;
      4'b00_10: c = 4'hC;
      4'b00_11: c = 4'h9;
      4'b01_00: c = 4'h3;
      4'b01_01: c = 4'h9;
      4'b01_10: c = 4'hC;
      4'b01_11: c = 4'h6;
      4'b10_00: c = 4'h1;
      4'b10_01: c = 4'h2;
      4'b10_10: c = 4'h4;
      4'b10_11: c = 4'h8;
      4'b11_00: c = 4'h1;
      4'b11_01: c = 4'h8;
      4'b11_10: c = 4'h4;
      default:  c = 4'h2;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] bi_full_lookup(logic ccw, logic [1:0] ph);
    logic [3:0] c;
    case ({ccw, ph})
      3'b0_00: c = 4'h4;
      3'b0_01: c = 4'h0;
      3'b0_10: c = 4'h1;
      3'b0_11: c = 4'h5;
      3'b1_00: c = 4'h4;
      3'b1_01: c = 4'h5;
      3'b1_10: c = 4'h1;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] bi_wave_lookup(logic ccw, logic [2:0] idx);
    logic [3:0] c;
    case ({ccw, idx})
      4'b0_000: c = 4'h5;
      4'b0_001: c = 4'h6;
      4'b0_010: c = 4'h4;
      4'b0_011: c = 4'h8;
      4'b0_100: c = 4'h0;
      4'b0_101: c = 4'h3;
      4'b0_110: c = 4'h1;
      4'b0_111: c = 4'hD;
      4'b1_000: c = 4'h1;
      4'b1_001: c = 4'h2;
      4'b1_010: c = 4'h0;
      4'b1_011: c = 4'hC;
      4'b1_100: c = 4'h4;
      4'b1_101: c = 4'h7;
      4'b1_110: c = 4'h5;
      default:  c = 4'h9;
    endcase
    return c;
  endfunction

  // one bipolar step; wave tables advance the phase every second half step
  function automatic bi_st_t bi_step(logic [1:0] tab, bi_st_t cur);
    bi_st_t n;
    n = cur;
    if (!tab[1]) begin
      n.code  = bi_full_lookup(tab[0], cur.phase);
      n.phase = cur.phase + 2'd1;
    end else begin
      n.code = bi_wave_lookup(tab[0], {cur.phase, cur.half});
      if (cur.half) begin
        n.half  = 1'b0;
        n.phase = cur.phase + 2'd1;
      end else begin
        n.half = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dsrs_chan_if.sv
// ----------------------------------------------------------------------------
// dsrs channel interfaces
// valid/ready channels for tick requests, results and the mode register
// ----------------------------------------------------------------------------
`default_nettype none

interface dsrs_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic uni_horizontal_sensor;
  logic uni_vertical_sensor;
  logic bi_vertical_sensor;
  logic bi_horizontal_sensor;

  modport source (
    output valid, kind, uni_horizontal_sensor, uni_vertical_sensor,
           bi_vertical_sensor, bi_horizontal_sensor,
    input  ready
  );
  modport sink (
    input  valid, kind, uni_horizontal_sensor, uni_vertical_sensor,
           bi_vertical_sensor, bi_horizontal_sensor,
    output ready
  );
endinterface

interface dsrs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] drive_word;
  logic       error_flag;
  logic       homing;
  logic       last_of_run;

  modport source (
    output valid, drive_word, error_flag, homing, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, drive_word, error_flag, homing, last_of_run,
    output ready
  );
endinterface

interface dsrs_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;

  modport source (output valid, mode, input ready);
  modport sink (input valid, mode, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dual_stepper_route_sequencer_core.sv
// path: a request waits in the input register until the queue has room, then its results
//   enter the queue; throughput: one request per cycle while there is room; a mode 4 run
//   tick yields two results; the four-entry queue drains one per cycle when out is ready
// reset: synchronous on rst_n low; power-on homing, mode register 1, queue empty
// no clearing pass; the block takes requests straight out of reset
// ----------------------------------------------------------------------------
// dual stepper route sequencer core
// input register, single-pass step unit and result queue for two steppers
// ----------------------------------------------------------------------------
`default_nettype none

module dual_stepper_route_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  dsrs_in_if.sink     in_chan,
  dsrs_cfg_if.sink    cfg_chan,
  dsrs_out_if.source  out_chan
);
  import dsrs_pkg::*;

  // mode register: to be written only while the block is idle; the block does not enforce it
  logic [2:0] mode_r;

  // input register stage
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      s1_go;
  logic      room;
  step_res_t step_res;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SINGLE;
    end else if (cfg_chan.valid) begin
      mode_r <= cfg_chan.mode;
    end
  end

  // the registered request moves on when the queue has two free slots,
  // so a two-result tick always fits
  assign s1_go         = s1_valid_r && room;
  assign in_chan.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_item_r <= '{kind:                  in_chan.kind,
                     uni_horizontal_sensor: in_chan.uni_horizontal_sensor,
                     uni_vertical_sensor:   in_chan.uni_vertical_sensor,
                     bi_vertical_sensor:    in_chan.bi_vertical_sensor,
                     bi_horizontal_sensor:  in_chan.bi_horizontal_sensor};
    end
  end

  // route state and coil codes advance once per consumed request
  dsrs_step_unit u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (s1_go),
    .item  (s1_item_r),
    .mode  (mode_r),
    .res   (step_res)
  );

  // results of the consumed request enter the queue in the same edge
  dsrs_res_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (s1_go),
    .res      (step_res),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// File: hw/rtl/dsrs_step_unit.sv
// ----------------------------------------------------------------------------
// dsrs step unit
// route state and single-pass next-state and result logic for one request
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_stepper_route_sequencer_core_macros.svh"

module dsrs_step_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  dsrs_pkg::in_item_t   item,
  input  logic [2:0]           mode,
  output dsrs_pkg::step_res_t  res
);
  import dsrs_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [1:0] uni_phase_r, uni_phase_nxt;
  logic [1:0] seg_r, seg_nxt;
  logic [3:0] uni_code_r, uni_code_nxt;
  bi_st_t     bi_r, bi_nxt;

  logic       mode_ok;
  plan_t      plan;
  logic       un, bn;
  bi_st_t     bi_one, bi_two;
  logic       hom;
  logic [3:0] uni_code_new;
  logic [3:0] bi_code_a, bi_code_b;

  assign mode_ok = (mode >= MODE_SINGLE) && (mode <= MODE_WAVE);
  assign plan    = plan_lookup(phase_r == PH_POWER_HOME, phase_r == PH_MODE_HOME,
                               mode, seg_r);
  assign un      = (plan.usens != SENS_NONE) && !sens_pick(plan.usens, item);
  assign bn      = (plan.bsens != SENS_NONE) && !sens_pick(plan.bsens, item);
  assign bi_one  = bn ? bi_step(plan.btab, bi_r) : bi_r;
  assign bi_two  = bn ? bi_step(plan.btab, bi_one) : bi_one;
  assign hom     = (phase_r != PH_RUN);

  assign uni_code_new = un ? uni_lookup(plan.utab, uni_phase_r) : uni_code_r;
  assign bi_code_a    = (plan.bsens != SENS_NONE) ? bi_one.code : 4'h0;
  assign bi_code_b    = (plan.bsens != SENS_NONE) ? bi_two.code : 4'h0;

  always_comb begin
    phase_nxt     = phase_r;
    uni_phase_nxt = uni_phase_r;
    seg_nxt       = seg_r;
    uni_code_nxt  = uni_code_r;
    bi_nxt        = bi_r;
    res           = '0;

    if (phase_r == PH_HALT) begin
      res.count = 2'd1;
      res.r0    = ERR_RESULT;
    end else if (item.kind) begin
      if (!mode_ok) begin
        phase_nxt = PH_HALT;
        res.count = 2'd1;
        res.r0    = ERR_RESULT;
      end else begin
        phase_nxt = (mode == MODE_SINGLE) ? PH_RUN : PH_MODE_HOME;
      end
    end else if ((phase_r != PH_POWER_HOME) && !mode_ok) begin
      // tick under a bad mode value: dropped
    end else if (!un && !bn) begin
      if (phase_r == PH_MODE_HOME) begin
        uni_phase_nxt = 2'd0;
        bi_nxt.phase  = 2'd0;
        seg_nxt       = 2'd0;
        phase_nxt     = PH_RUN;
      end else if (phase_r == PH_RUN) begin
        if (mode == MODE_SINGLE) seg_nxt = seg_r + 2'd1;
        else                     seg_nxt = (seg_r == 2'd0) ? 2'd1 : 2'd0;
      end
    end else begin
      uni_code_nxt = uni_code_new;
      if (un) uni_phase_nxt = uni_phase_r + 2'd1;
      res.r0.drive_word = {bi_code_a,
                           (plan.usens != SENS_NONE) ? uni_code_new : 4'h0};
      res.r0.homing     = hom;
      if (plan.twice) begin
        bi_nxt            = bi_two;
        res.count         = 2'd2;
        res.r0.last_of_run = 1'b0;
        res.r1.drive_word = {bi_code_b,
                             (plan.usens != SENS_NONE) ? uni_code_new : 4'h0};
        res.r1.homing     = hom;
        res.r1.last_of_run = 1'b1;
      end else begin
        bi_nxt             = bi_one;
        res.count          = 2'd1;
        res.r0.last_of_run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_POWER_HOME;
      uni_phase_r <= 2'd0;
      seg_r       <= 2'd0;
      uni_code_r  <= 4'h0;
      bi_r        <= '{code: BI_CODE_RST, phase: 2'd0, half: 1'b0};
    end else if (go) begin
      phase_r     <= phase_nxt;
      uni_phase_r <= uni_phase_nxt;
      seg_r       <= seg_nxt;
      uni_code_r  <= uni_code_nxt;
      bi_r        <= bi_nxt;
    end
  end

  // halt is left only by reset
  `DSRS_ASSERT_NEXT(a_halt_sticky, phase_r == PH_HALT, phase_r == PH_HALT)
  // only the final result of a request is marked last
  `DSRS_ASSERT_IMPL(a_last_mark, res.count == 2'd2,
                    !res.r0.last_of_run && res.r1.last_of_run)
  // error results never carry coil drive
  `DSRS_ASSERT_IMPL(a_err_quiet, (res.count != 2'd0) && res.r0.error_flag,
                    (res.r0.drive_word == 8'h00) && (res.count == 2'd1))

endmodule

`default_nettype wire

// File: hw/rtl/dsrs_res_queue.sv
// ----------------------------------------------------------------------------
// dsrs result queue
// small queue that takes up to two results a cycle and drives the out channel
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_stepper_route_sequencer_core_macros.svh"

module dsrs_res_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dsrs_pkg::step_res_t res,
  output logic                room,
  dsrs_out_if.source          out_chan
);
  import dsrs_pkg::*;

  result_t          q_r [QDEPTH];
  logic [QPTRW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTRW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNTW-1:0] cnt_r, cnt_nxt;
  logic [1:0]       push_cnt;
  logic             pop;
  logic [QPTRW-1:0] wr_ptr_p1;

  assign push_cnt  = push ? res.count : 2'd0;
  assign pop       = out_chan.valid && out_chan.ready;
  assign room      = (cnt_r <= QCNTW'(QDEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + QPTRW'(1);

  assign wr_ptr_nxt = wr_ptr_r + QPTRW'(push_cnt);
  assign rd_ptr_nxt = pop ? rd_ptr_r + QPTRW'(1) : rd_ptr_r;
  assign cnt_nxt    = cnt_r + QCNTW'(push_cnt) - QCNTW'(pop);

  assign out_chan.valid       = (cnt_r != '0);
  assign out_chan.drive_word  = q_r[rd_ptr_r].drive_word;
  assign out_chan.error_flag  = q_r[rd_ptr_r].error_flag;
  assign out_chan.homing      = q_r[rd_ptr_r].homing;
  assign out_chan.last_of_run = q_r[rd_ptr_r].last_of_run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) q_r[wr_ptr_r]  <= res.r0;
    if (push_cnt == 2'd2) q_r[wr_ptr_p1] <= res.r1;
  end

  // a push only lands when two slots are free
  `DSRS_ASSERT_IMPL(a_push_room, push_cnt != 2'd0, room)
  // occupancy never passes the depth
  `DSRS_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= QCNTW'(QDEPTH))

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual stepper route sequencer testbench
// drives tick and start requests through all route modes, checks every drive
// word against a cycle-free model of the sequencer kept in a scoreboard
// ----------------------------------------------------------------------------

module testbench;
  import dsrs_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 8;
  // requests without a drive word may still be in flight when the queue empties
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 120;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int MAX_REPORTS   = 40;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // register extremes outside the valid route modes
  localparam logic [2:0] MODE_BAD_LOW  = 3'd0;
  localparam logic [2:0] MODE_BAD_HIGH = 3'd7;

  // coil codes, indexed [table][phase]
  localparam logic [3:0][3:0][3:0] UNI_SEQ     = 64'h2481_8421_6C93_9C63;
  // indexed [ccw][phase]
  localparam logic [1:0][3:0][3:0] BI_FULL_SEQ = 32'h0154_5104;
  // indexed [ccw][{phase, half}]
  localparam logic [1:0][7:0][3:0] BI_WAVE_SEQ = 64'h9574C021_D1308465;

  typedef struct packed {
    logic [2:0] usel;
    logic [1:0] utab;
    logic [2:0] bsel;
    logic [1:0] btab;
    logic       twice;
  } route_t;

  class drive_word_scoreboard;
    logic [2:0] mode;
    logic [1:0] uni_phase;
    logic [1:0] bi_phase;
    logic       bi_half;
    logic [1:0] segment;
    phase_t     run_phase;
    logic [3:0] uni_code;
    logic [3:0] bi_code;
    result_t    expected_words[$];
    int         requests;
    int         words_checked;
    int         homing_words;
    int         error_words;
    int         twin_ticks;
    int         errors;

    function new();
      mode          = MODE_SINGLE;
      uni_phase     = 2'd0;
      bi_phase      = 2'd0;
      bi_half       = 1'b0;
      segment       = 2'd0;
      run_phase     = PH_POWER_HOME;
      uni_code      = 4'h0;
      bi_code       = BI_CODE_RST;
      requests      = 0;
      words_checked = 0;
      homing_words  = 0;
      error_words   = 0;
      twin_ticks    = 0;
      errors        = 0;
    endfunction

    function void set_mode(logic [2:0] m);
      mode = m;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function logic sensor_blocked(logic [2:0] sel, in_item_t it);
      case (sel)
        SENS_UNI_H: return it.uni_horizontal_sensor;
        SENS_UNI_V: return it.uni_vertical_sensor;
        SENS_BI_V:  return it.bi_vertical_sensor;
        SENS_BI_H:  return it.bi_horizontal_sensor;
        default:    return 1'b0;
      endcase
    endfunction

    function void step_bi(logic [1:0] tab);
      logic ccw;
      ccw = (tab == TAB_CCW_FULL) || (tab == TAB_CCW_WAVE);
      if (tab == TAB_CW_FULL || tab == TAB_CCW_FULL) begin
        bi_code  = BI_FULL_SEQ[ccw][bi_phase];
        bi_phase = bi_phase + 2'd1;
      end else begin
        bi_code = BI_WAVE_SEQ[ccw][{bi_phase, bi_half}];
        if (bi_half) begin
          bi_half  = 1'b0;
          bi_phase = bi_phase + 2'd1;
        end else begin
          bi_half = 1'b1;
        end
      end
    endfunction

    // only motors that take part in the segment show their nibble
    function void push_word(route_t r, logic homing, logic last);
      result_t w;
      w.drive_word  = {(r.bsel != SENS_NONE) ? bi_code : 4'h0,
                       (r.usel != SENS_NONE) ? uni_code : 4'h0};
      w.error_flag  = 1'b0;
      w.homing      = homing;
      w.last_of_run = last;
      expected_words.push_back(w);
    endfunction

    function void note_request(in_item_t it);
      logic   valid_mode;
      route_t r;
      logic   uni_go;
      logic   bi_go;
      logic   homing;
      requests++;
      valid_mode = (mode >= MODE_SINGLE) && (mode <= MODE_WAVE);
      if (run_phase == PH_HALT) begin
        expected_words.push_back(ERR_RESULT);
        return;
      end
      if (it.kind == KIND_START) begin
        if (!valid_mode) begin
          run_phase = PH_HALT;
          expected_words.push_back(ERR_RESULT);
        end else begin
          run_phase = (mode == MODE_SINGLE) ? PH_RUN : PH_MODE_HOME;
        end
        return;
      end
      if (run_phase != PH_POWER_HOME && !valid_mode) return;

      r = '{SENS_NONE, TAB_CW_FULL, SENS_NONE, TAB_CW_FULL, 1'b0};
      if (run_phase == PH_POWER_HOME) begin
        r = '{SENS_UNI_H, TAB_CCW_FULL, SENS_BI_H, TAB_CCW_FULL, 1'b0};
      end else if (run_phase == PH_MODE_HOME) begin
        case (mode)
          MODE_PAIR:  r = '{SENS_UNI_H, TAB_CCW_FULL, SENS_BI_H, TAB_CCW_FULL, 1'b0};
          MODE_CROSS: r = '{SENS_UNI_V, TAB_CCW_FULL, SENS_BI_H, TAB_CCW_FULL, 1'b0};
          MODE_WAVE:  r = '{SENS_UNI_H, TAB_CW_WAVE, SENS_BI_H, TAB_CW_WAVE, 1'b0};
          default:    r = '{SENS_NONE, TAB_CW_FULL, SENS_NONE, TAB_CW_FULL, 1'b0};
        endcase
      end else begin
        case (mode)
          MODE_SINGLE: begin
            case (segment)
              2'd0:    r = '{SENS_UNI_V, TAB_CCW_FULL, SENS_NONE, TAB_CW_FULL, 1'b0};
              2'd1:    r = '{SENS_NONE, TAB_CW_FULL, SENS_BI_V, TAB_CW_FULL, 1'b0};
              2'd2:    r = '{SENS_UNI_H, TAB_CW_FULL, SENS_NONE, TAB_CW_FULL, 1'b0};
              default: r = '{SENS_NONE, TAB_CW_FULL, SENS_BI_H, TAB_CCW_FULL, 1'b0};
            endcase
          end
          MODE_PAIR: begin
            if (!segment[0]) r = '{SENS_UNI_V, TAB_CCW_FULL, SENS_BI_V, TAB_CW_FULL, 1'b0};
            else             r = '{SENS_UNI_H, TAB_CW_FULL, SENS_BI_H, TAB_CCW_FULL, 1'b0};
          end
          MODE_CROSS: begin
            if (!segment[0]) r = '{SENS_UNI_H, TAB_CCW_FULL, SENS_BI_V, TAB_CCW_FULL, 1'b0};
            else             r = '{SENS_UNI_V, TAB_CW_FULL, SENS_BI_H, TAB_CW_FULL, 1'b0};
          end
          default: begin
            if (!segment[0]) r = '{SENS_UNI_V, TAB_CCW_WAVE, SENS_BI_V, TAB_CW_WAVE, 1'b1};
            else             r = '{SENS_UNI_H, TAB_CW_WAVE, SENS_BI_H, TAB_CCW_WAVE, 1'b1};
          end
        endcase
      end

      uni_go = (r.usel != SENS_NONE) && !sensor_blocked(r.usel, it);
      bi_go  = (r.bsel != SENS_NONE) && !sensor_blocked(r.bsel, it);

      if (!uni_go && !bi_go) begin
        if (run_phase == PH_MODE_HOME) begin
          uni_phase = 2'd0;
          bi_phase  = 2'd0;
          segment   = 2'd0;
          run_phase = PH_RUN;
        end else if (run_phase == PH_RUN) begin
          if (mode == MODE_SINGLE) segment = segment + 2'd1;
          else                     segment = (segment == 2'd0) ? 2'd1 : 2'd0;
        end
        return;
      end

      homing = (run_phase != PH_RUN);
      if (uni_go) begin
        uni_code  = UNI_SEQ[r.utab][uni_phase];
        uni_phase = uni_phase + 2'd1;
      end
      if (bi_go) step_bi(r.btab);
      if (!r.twice) begin
        push_word(r, homing, 1'b1);
        return;
      end
      twin_ticks++;
      push_word(r, homing, 1'b0);
      if (bi_go) step_bi(r.btab);
      push_word(r, homing, 1'b1);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: drive word with no request pending, expected none, actual %h",
                   $time, got);
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (want.homing) homing_words++;
      if (want.error_flag) error_words++;
      compare_field("drive_word", want.drive_word, got.drive_word);
      compare_field("error_flag", 8'(want.error_flag), 8'(got.error_flag));
      compare_field("homing", 8'(want.homing), 8'(got.homing));
      compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dsrs_in_if  in_chan();
  dsrs_out_if out_chan();
  dsrs_cfg_if cfg_chan();

  drive_word_scoreboard sb;

  // idle odds in percent per cycle, changed between regimes
  int src_idle_pct;
  int snk_idle_pct;
  // asks the receiver for one long hold-off
  bit hold_req;
  int stall_cycles;

  dual_stepper_route_sequencer_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic in_item_t make_item(logic kind, logic uh, logic uv, logic bv, logic bh);
    in_item_t it;
    it.kind                  = kind;
    it.uni_horizontal_sensor = uh;
    it.uni_vertical_sensor   = uv;
    it.bi_vertical_sensor    = bv;
    it.bi_horizontal_sensor  = bh;
    return it;
  endfunction

  // mostly biased sensor patterns, a few fully random ones as noise
  function automatic in_item_t random_request(int start_pct, int block_pct, bit allow_start);
    in_item_t   it;
    logic [4:0] raw;
    if ($urandom_range(99) < 6) begin
      raw = 5'($urandom_range(31));
      it  = raw;
    end else begin
      it = make_item(($urandom_range(99) < start_pct) ? KIND_START : KIND_TICK,
                     $urandom_range(99) < block_pct, $urandom_range(99) < block_pct,
                     $urandom_range(99) < block_pct, $urandom_range(99) < block_pct);
    end
    if (!allow_start) it.kind = KIND_TICK;
    return it;
  endfunction

  // offer one request, optionally after an idle gap, and wait for the handshake
  task automatic send_request(input in_item_t it);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid                 <= 1'b1;
    in_chan.kind                  <= it.kind;
    in_chan.uni_horizontal_sensor <= it.uni_horizontal_sensor;
    in_chan.uni_vertical_sensor   <= it.uni_vertical_sensor;
    in_chan.bi_vertical_sensor    <= it.bi_vertical_sensor;
    in_chan.bi_horizontal_sensor  <= it.bi_horizontal_sensor;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_request(it);
  endtask

  task automatic write_mode(input logic [2:0] m);
    cfg_chan.valid <= 1'b1;
    cfg_chan.mode  <= m;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    sb.set_mode(m);
    cfg_chan.valid <= 1'b0;
  endtask

  // sender pause until every drive word is back
  task automatic drain_words();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // block idle: nothing expected and nothing left in flight
  task automatic quiesce();
    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random ready, one long hold-off on request
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_chan.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // every accepted drive word goes to the scoreboard
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.drive_word  = out_chan.drive_word;
      got.error_flag  = out_chan.error_flag;
      got.homing      = out_chan.homing;
      got.last_of_run = out_chan.last_of_run;
      sb.check_result(got);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
                 (cfg_chan.valid && cfg_chan.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d drive words outstanding",
               $time, stall_cycles, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int         regime;
    int         k;
    int         n;
    int         regime_items;
    bit         first_block;
    in_item_t   item;
    logic [2:0] bad_mode;

    sb           = new();
    hold_req     = 1'b0;
    src_idle_pct = 14;
    snk_idle_pct = 57;
    stall_cycles = 0;

    rst_n                         <= 1'b0;
    in_chan.valid                 <= 1'b0;
    in_chan.kind                  <= KIND_TICK;
    in_chan.uni_horizontal_sensor <= 1'b0;
    in_chan.uni_vertical_sensor   <= 1'b0;
    in_chan.bi_vertical_sensor    <= 1'b0;
    in_chan.bi_horizontal_sensor  <= 1'b0;
    cfg_chan.valid                <= 1'b0;
    cfg_chan.mode                 <= MODE_SINGLE;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // power-on homing steps whatever the register holds
    write_mode(MODE_BAD_LOW);
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    // uni home reached, bi keeps going
    send_request(make_item(KIND_TICK, 1'b1, 1'b0, 1'b0, 1'b0));
    // both home: power-on homing just idles
    send_request(make_item(KIND_TICK, 1'b1, 1'b0, 1'b0, 1'b1));

    // mode 1 runs at once, one motor per segment, all four segments and the wrap
    quiesce();
    write_mode(MODE_SINGLE);
    send_request(make_item(KIND_START, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(make_item(KIND_TICK, 1'b0, 1'b1, 1'b0, 1'b0));
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b1, 1'b0));
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(make_item(KIND_TICK, 1'b1, 1'b0, 1'b0, 1'b0));
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b1));

    // mode 2: homing, homing done, first segment
    quiesce();
    write_mode(MODE_PAIR);
    send_request(make_item(KIND_START, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(make_item(KIND_TICK, 1'b1, 1'b0, 1'b0, 1'b1));
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));

    // mode 3 homes uni to its vertical sensor
    quiesce();
    write_mode(MODE_CROSS);
    send_request(make_item(KIND_START, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(make_item(KIND_TICK, 1'b0, 1'b1, 1'b0, 1'b1));

    // mode 4: double bipolar step, then a tick where bi is blocked
    quiesce();
    write_mode(MODE_WAVE);
    send_request(make_item(KIND_START, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(make_item(KIND_TICK, 1'b1, 1'b0, 1'b0, 1'b1));
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b1, 1'b0));

    // mode 1 selected during mode homing ends homing at once
    quiesce();
    write_mode(MODE_PAIR);
    send_request(make_item(KIND_START, 1'b0, 1'b0, 1'b0, 1'b0));
    quiesce();
    write_mode(MODE_SINGLE);
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));

    // backpressure: receiver holds off while mode 4 homing keeps producing words
    quiesce();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_mode(MODE_WAVE);
    send_request(make_item(KIND_START, 1'b0, 1'b0, 1'b0, 1'b0));
    hold_req = 1'b1;
    repeat (40) send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));

    // random routes under three idle regimes
    for (regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          src_idle_pct = 14;
          snk_idle_pct = 57;
        end
        1: begin
          src_idle_pct = 57;
          snk_idle_pct = 14;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      regime_items = 0;
      first_block  = 1'b1;
      while (regime_items < RANDOM_ITEMS / 3) begin
        quiesce();
        if ($urandom_range(99) < 12) begin
          // invalid mode mid-run: ticks are ignored, 8 truncates to 0
          bad_mode = 3'($urandom_range(5, 8));
          write_mode(bad_mode);
          n = $urandom_range(4, 10);
          repeat (n) send_request(random_request(0, 35, 1'b0));
        end else begin
          write_mode(3'($urandom_range(MODE_SINGLE, MODE_WAVE)));
          n = $urandom_range(20, 60);
          for (k = 0; k < n; k++) begin
            if (k == 0 && $urandom_range(99) < 70)
              item = make_item(KIND_START, 1'b0, 1'b0, 1'b0, 1'b0);
            else
              item = random_request(3, 35, 1'b1);
            if (first_block && k == n / 2) drain_words();
            send_request(item);
            regime_items++;
          end
          first_block = 1'b0;
        end
      end
    end

    // invalid start halts the block for good
    quiesce();
    src_idle_pct = 14;
    snk_idle_pct = 57;
    write_mode(MODE_BAD_HIGH);
    send_request(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(make_item(KIND_START, 1'b0, 1'b0, 1'b0, 1'b0));
    repeat (16) send_request(random_request(30, 50, 1'b1));

    quiesce();
    $display("run covered %0d requests over power-on and mode homing, all four routes,",
             sb.requests);
    $display("mode changes, invalid modes and halt: %0d words (%0d homing, %0d error, %0d twin)",
             sb.words_checked, sb.homing_words, sb.error_words, sb.twin_ticks);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: dual_stepper_route_sequencer_core.f
+incdir+hw/rtl
hw/rtl/dsrs_pkg.sv
hw/rtl/dsrs_chan_if.sv
hw/rtl/dsrs_step_unit.sv
hw/rtl/dsrs_res_queue.sv
hw/rtl/dual_stepper_route_sequencer_core.sv
tb/testbench.sv
